// File: rtl/pvl_pkg.sv
package pvl_pkg;

  localparam int POS_W = 24;
  localparam int MIX_W = 17;
  localparam int WID_W = 23;
  localparam int CFG_W = 24;
  localparam int IDX_W = 2;

  localparam int OUT_FRAC_BITS = 16;
  localparam int OUT_W = OUT_FRAC_BITS + 1;

  localparam logic [IDX_W-1:0] REG_MIX = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_CENTER = 2'd2;

  localparam logic [MIX_W-1:0] ONE_Q16 = 17'd65536;

  localparam int DIV_NW = 49;
  localparam int DIV_DW = 33;
  localparam int DIV_SPS = 3;
  localparam int DIV_STAGES = DIV_DW / DIV_SPS;

  localparam int FRAC_BITS_U = 16;
  localparam int NST = 35;

  typedef struct packed {
    logic vld;
    logic last;
    logic sat;
  } ctl_t;

  function automatic logic [63:0] pvl_isqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] rem;
    res = '0;
    bit_v = 64'h4000_0000_0000_0000;
    rem = n;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^32 * 2^(-2^-j)
  function automatic logic [31:0] pvl_root(input int j);
    logic [63:0] r;
    r = 64'h0000_0000_8000_0000;
    for (int i = 1; i <= 16; i++) begin
      if (i <= j) begin
        r = pvl_isqrt(r << 32);
      end
    end
    return r[31:0];
  endfunction

endpackage

// File: rtl/pvl_div.sv
module pvl_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [pvl_pkg::DIV_NW-1:0] div_num,
  input  logic [pvl_pkg::DIV_DW-1:0] div_den,
  output logic [pvl_pkg::DIV_DW-1:0] div_quo
);
  import pvl_pkg::*;

  logic [DIV_DW-1:0] rem_r [DIV_STAGES];
  logic [DIV_DW-1:0] wrk_r [DIV_STAGES];
  logic [DIV_DW-1:0] den_r [DIV_STAGES];
  logic [DIV_DW-1:0] rem_nxt [DIV_STAGES];
  logic [DIV_DW-1:0] wrk_nxt [DIV_STAGES];
  logic [DIV_DW-1:0] den_nxt [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DIV_DW-1:0] src_rem;
    logic [DIV_DW-1:0] src_quo;
    logic [DIV_DW-1:0] src_den;

    if (s == 0) begin : g_src
      assign src_rem = DIV_DW'(div_num[DIV_NW-1:DIV_DW]);
      assign src_quo = div_num[DIV_DW-1:0];
      assign src_den = div_den;
    end else begin : g_src
      assign src_rem = rem_r[s-1];
      assign src_quo = wrk_r[s-1];
      assign src_den = den_r[s-1];
    end

    always_comb begin
      logic [DIV_DW:0]   t;
      logic [DIV_DW-1:0] r;
      logic [DIV_DW-1:0] q;
      logic [DIV_DW-1:0] d;
      logic              ge;
      r = src_rem;
      q = src_quo;
      d = src_den;
      for (int i = 0; i < DIV_SPS; i++) begin
        t = {r, q[DIV_DW-1]};
        ge = (t >= {1'b0, d});
        q = {q[DIV_DW-2:0], ge};
        r = ge ? DIV_DW'(t - {1'b0, d}) : t[DIV_DW-1:0];
      end
      rem_nxt[s] = r;
      wrk_nxt[s] = q;
      den_nxt[s] = d;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt[s];
        wrk_r[s] <= wrk_nxt[s];
        den_r[s] <= den_nxt[s];
      end
    end
  end

  assign div_quo = wrk_r[DIV_STAGES-1];

endmodule

// File: rtl/pseudo_voigt_lineshape.sv
// Pseudo-Voigt line shape: each word carries a Q2.22 position and returns
// mix/(1+u) + (1-mix)*2^-u with u = (2*(position-center)/width)^2, as Q1.16
// in 0..65536; points with |2*(position-center)/width| >= 256 give 0. The
// block takes one word per clock while the output side does not stall; its
// pipeline holds two 33-step dividers (3 quotient bits per stage, 11 stages
// each) and the 16-stage multiply chain of the exponential. A stall at the
// output freezes the whole pipeline. Registers (index: mix 0, width_fwhm 1,
// center 2) may be written only while no word is in flight; mix above 65536
// acts as 65536, width 0 acts as 1.
module pseudo_voigt_lineshape (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [pvl_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pvl_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pvl_pkg::POS_W-1:0]  in_sample_position,
  input  logic                              in_is_last_point,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pvl_pkg::OUT_W-1:0]         out_line_value,
  output logic                              out_last_out
);
  import pvl_pkg::*;

  localparam int RND_SH = 32 - OUT_FRAC_BITS;
  localparam logic [33:0] RND_ADD = 34'(1) << (31 - OUT_FRAC_BITS);
  localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(1) << OUT_FRAC_BITS;
  localparam logic [32:0] G_ONE = 33'(1) << 32;

  logic [MIX_W-1:0] mix_r;
  logic [WID_W-1:0] width_r;
  logic [POS_W-1:0] center_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_r <= ONE_Q16;
      width_r <= 23'd1048576;
      center_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIX: begin
          mix_r <= (cfg_wdata[MIX_W-1:0] > ONE_Q16) ? ONE_Q16 : cfg_wdata[MIX_W-1:0];
        end
        REG_WIDTH: begin
          width_r <= (cfg_wdata[WID_W-1:0] == '0) ? WID_W'(1) : cfg_wdata[WID_W-1:0];
        end
        REG_CENTER: begin
          center_r <= cfg_wdata[POS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  logic en;
  ctl_t ctl_r [1:NST];
  ctl_t ctl_nxt [1:NST];

  assign en = !ctl_r[NST].vld || out_ready;
  assign in_ready = en;

  logic signed [POS_W:0] d_r;
  logic [POS_W-1:0] a_r;

  always_comb begin
    ctl_nxt[1] = '{vld: in_valid, last: in_is_last_point, sat: 1'b0};
    for (int s = 2; s <= NST; s++) begin
      ctl_nxt[s] = ctl_r[s-1];
    end
    ctl_nxt[3].sat = ({6'd0, a_r} >= {width_r, 7'd0});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= {in_sample_position[POS_W-1], in_sample_position} -
             {center_r[POS_W-1], center_r};
      a_r <= d_r[POS_W] ? POS_W'(-d_r) : d_r[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) begin
        ctl_r[s] <= '0;
      end
    end else if (en) begin
      for (int s = 1; s <= NST; s++) begin
        ctl_r[s] <= ctl_nxt[s];
      end
    end
  end

  logic [DIV_DW-1:0] xq;

  pvl_div u_xdiv (
    .clk     (clk),
    .en      (en),
    .div_num ({8'd0, a_r, 17'd0}),
    .div_den ({10'd0, width_r}),
    .div_quo (xq)
  );

  logic [47:0] sq_r;
  logic [31:0] u_r;
  logic [32:0] v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= 48'(xq[23:0]) * 48'(xq[23:0]);
      u_r <= 32'((49'(sq_r) + 49'd32768) >> FRAC_BITS_U);
      v_r <= 33'(u_r) + 33'(ONE_Q16);
    end
  end

  logic [DIV_DW-1:0] lor_q;

  pvl_div u_ldiv (
    .clk     (clk),
    .en      (en),
    .div_num ({mix_r, 32'd0}),
    .div_den (v_r),
    .div_quo (lor_q)
  );

  logic [32:0] lor_d_r [1:6];

  always_ff @(posedge clk) begin
    if (en) begin
      lor_d_r[1] <= lor_q;
      for (int i = 2; i <= 6; i++) begin
        lor_d_r[i] <= lor_d_r[i-1];
      end
    end
  end

  logic [32:0] g_r [1:16];
  logic [15:0] f_r [1:16];
  logic [15:0] k_r [1:16];

  for (genvar b = 0; b < 16; b++) begin : g_exp
    localparam logic [31:0] RK = pvl_root(16 - b);
    logic [32:0] gin;
    logic [15:0] fin;
    logic [15:0] kin;
    logic [64:0] prod;

    if (b == 0) begin : g_first
      assign gin = G_ONE;
      assign fin = u_r[15:0];
      assign kin = u_r[31:16];
    end else begin : g_next
      assign gin = g_r[b];
      assign fin = f_r[b];
      assign kin = k_r[b];
    end

    assign prod = 65'(gin) * 65'(RK);

    always_ff @(posedge clk) begin
      if (en) begin
        g_r[b+1] <= fin[b] ? prod[64:32] : gin;
        f_r[b+1] <= fin;
        k_r[b+1] <= kin;
      end
    end
  end

  logic [32:0] gs_r;
  logic [49:0] gprod;
  logic [32:0] gau_r;
  logic [33:0] s_r;
  logic [33:0] rnd;
  logic [OUT_W-1:0] res;

  assign gprod = 50'(ONE_Q16 - mix_r) * 50'(gs_r);
  assign rnd = (s_r + RND_ADD) >> RND_SH;

  always_comb begin
    if (ctl_r[NST-1].sat) begin
      res = '0;
    end else if (rnd > 34'(OUT_MAX)) begin
      res = OUT_MAX;
    end else begin
      res = rnd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gs_r <= (|k_r[16][15:6]) ? 33'd0 : (g_r[16] >> k_r[16][5:0]);
      gau_r <= gprod[48:16];
      s_r <= 34'(lor_d_r[6]) + 34'(gau_r);
      out_line_value <= res;
    end
  end

  assign out_valid = ctl_r[NST].vld;
  assign out_last_out = ctl_r[NST].last;

`ifndef ASSERT_OFF
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ctl_r[1].vld)
    else $error("accepted word missing from first stage");

  a_far_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && ctl_r[NST-1].vld && ctl_r[NST-1].sat |=> out_line_value == '0)
    else $error("saturated point gave nonzero value");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_value <= OUT_MAX)
    else $error("line value above one");

  a_mix_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    mix_r <= ONE_Q16)
    else $error("mix register above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(ctl_r[NST/2]) && $stable(u_r))
    else $error("pipeline moved during stall");
`endif

endmodule

// File: test/tb_pseudo_voigt_lineshape.sv
`timescale 1ns / 100ps

module tb_pseudo_voigt_lineshape;
  import pvl_pkg::*;

  typedef struct {
    logic [OUT_W-1:0] value;
    logic             last;
  } line_word_t;

  typedef struct {
    logic signed [POS_W-1:0] pos;
    logic                    last;
    bit                      typed;
    logic [OUT_W-1:0]        value;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_wr_en;
  logic [IDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_wdata;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [POS_W-1:0] in_sample_position;
  logic                    in_is_last_point;
  logic                    out_valid;
  logic                    out_ready;
  logic [OUT_W-1:0]        out_line_value;
  logic                    out_last_out;

  logic [MIX_W-1:0]        mix_q;
  logic [WID_W-1:0]        width_q;
  logic signed [POS_W-1:0] center_q;
  logic [63:0]             exp_roots [0:16];

  line_word_t  pending_lines[$];
  int          error_count;
  int          sender_idle_pct;
  int          receiver_idle_pct;
  int          hold_cycles;

  pseudo_voigt_lineshape dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_position (in_sample_position),
    .in_is_last_point   (in_is_last_point),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_line_value     (out_line_value),
    .out_last_out       (out_last_out)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #20ms;
    $display("pseudo_voigt_lineshape regression: fail");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [OUT_W-1:0] line_height(input logic signed [POS_W-1:0] pos);
    logic signed [63:0] d;
    logic [63:0] a, w, m, x, u, lor, k, f, g, s, r;
    d = 64'(pos) - 64'(center_q);
    a = (d < 0) ? -d : d;
    w = (width_q == 0) ? 64'd1 : 64'(width_q);
    m = (mix_q > ONE_Q16) ? 64'd65536 : 64'(mix_q);
    x = (a << 17) / w;
    if (x >= (64'd1 << 24)) return '0;
    u = (x * x + 64'd32768) >> 16;
    lor = (m << 32) / (64'd65536 + u);
    k = u >> 16;
    f = u & 64'hFFFF;
    g = 64'd1 << 32;
    for (int b = 0; b < 16; b++) begin
      if (f[b]) g = (g * exp_roots[16-b]) >> 32;
    end
    g = (k >= 64) ? 64'd0 : (g >> k);
    s = lor + (((64'd65536 - m) * g) >> 16);
    r = (s + (64'd1 << (31 - OUT_FRAC_BITS))) >> (32 - OUT_FRAC_BITS);
    if (r > (64'd1 << OUT_FRAC_BITS)) r = 64'd1 << OUT_FRAC_BITS;
    return r[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MIX:    mix_q = val[MIX_W-1:0];
      REG_WIDTH:  width_q = val[WID_W-1:0];
      REG_CENTER: center_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_point(input logic signed [POS_W-1:0] pos, input logic last,
                            input bit typed, input logic [OUT_W-1:0] value);
    line_word_t w;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_position <= pos;
    in_is_last_point <= last;
    w.value = line_height(pos);
    w.last = last;
    if (typed && w.value != value)
      report_mismatch($sformatf("table row pos %0d predicts %0d, row says %0d",
                                pos, w.value, value));
    if (typed) w.value = value;
    do @(posedge clk); while (!in_ready);
    pending_lines.push_back(w);
  endtask

  always @(posedge clk) begin
    line_word_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lines.size() == 0) begin
        report_mismatch("unexpected word");
      end else begin
        w = pending_lines.pop_front();
        if (out_line_value !== w.value)
          report_mismatch($sformatf("line_value %0d, want %0d", out_line_value, w.value));
        if (out_last_out !== w.last)
          report_mismatch($sformatf("last_out %0b, want %0b", out_last_out, w.last));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(receiver_idle_pct > 0 && $urandom_range(99) < receiver_idle_pct);
    end
  end

  initial begin
    stim_row_t rows[$];
    logic signed [POS_W-1:0] pos;
    int n;
    exp_roots[0] = 64'd1 << 31;
    for (int j = 1; j <= 16; j++) exp_roots[j] = int_sqrt(exp_roots[j-1] << 32);
    error_count = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    hold_cycles = 0;
    mix_q = 17'd65536;
    width_q = 23'd1048576;
    center_q = '0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_MIX;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_sample_position <= '0;
    in_is_last_point <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{24'sd0, 1'b0, 1'b1, 17'd65536},
      '{24'sd524288, 1'b0, 1'b1, 17'd32768},
      '{-24'sd524288, 1'b1, 1'b1, 17'd32768},
      '{24'sd8388607, 1'b0, 1'b0, 17'd0},
      '{-24'sd8388608, 1'b1, 1'b0, 17'd0},
      '{24'sd1048576, 1'b0, 1'b1, 17'd13107},
      '{24'sd12345, 1'b1, 1'b0, 17'd0}
    };
    foreach (rows[i]) send_point(rows[i].pos, rows[i].last, rows[i].typed, rows[i].value);
    drain();

    write_reg(REG_MIX, 24'd0);
    foreach (rows[i]) send_point(rows[i].pos, rows[i].last, 1'b0, '0);
    drain();
    write_reg(REG_MIX, 24'h1FFFF);
    write_reg(REG_WIDTH, 24'd0);
    send_point(24'sd0, 1'b0, 1'b1, 17'd65536);
    send_point(24'sd1, 1'b1, 1'b0, '0);
    send_point(24'sd40, 1'b0, 1'b0, '0);
    drain();
    write_reg(REG_WIDTH, 24'h7FFFFF);
    write_reg(REG_CENTER, 24'h800000);
    send_point(24'sd8388607, 1'b1, 1'b0, '0);
    send_point(-24'sd8388608, 1'b0, 1'b1, 17'd65536);
    send_point(-24'sd4194304, 1'b0, 1'b0, '0);
    drain();
    write_reg(REG_CENTER, 24'h7FFFFF);
    write_reg(REG_MIX, 24'd32768);
    send_point(24'sd8388607, 1'b0, 1'b0, '0);
    send_point(24'sd0, 1'b1, 1'b0, '0);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      sender_idle_pct = (phase < 3) ? 27 : (phase < 6) ? 75 : 0;
      receiver_idle_pct = (phase < 3) ? 75 : (phase < 6) ? 27 : 0;
      drain();
      write_reg(REG_MIX, (phase == 1) ? 24'd0 : (phase == 4) ? 24'd65536 :
                CFG_W'($urandom_range(65536 + 300)));
      write_reg(REG_WIDTH, (phase == 2) ? 24'd1 : (phase == 5) ? 24'h7FFFFF :
                CFG_W'($urandom_range(23'h7FFFFF >> ($urandom_range(1) * 12), 1)));
      write_reg(REG_CENTER, (phase == 7) ? 24'h800000 : CFG_W'($urandom));
      if (phase == 8) hold_cycles = 300;
      n = 78;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0: pos = POS_W'($urandom);
          1: pos = center_q + $signed(24'($urandom_range(4 * width_q + 1))) -
                   $signed(24'(2 * width_q));
          2: pos = center_q + $signed(24'($urandom_range(64 * width_q + 1))) -
                   $signed(24'(32 * width_q));
          default: pos = center_q + $signed(24'($urandom_range(600))) - 24'sd300;
        endcase
        send_point(pos, 1'($urandom_range(1)), 1'b0, '0);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("pseudo_voigt_lineshape regression: pass");
    end else begin
      $display("pseudo_voigt_lineshape regression: fail");
    end
    $finish;
  end

endmodule
